// File: hw/rtl/sos_pkg.sv
package sos_pkg;

  localparam int SAMPLES_DEF      = 512;
  localparam int MAX_SEGMENTS_DEF = 64;

  // Depths of the two queues, powers of two.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam int DIST_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEPS  = 3'd4;

  localparam logic [17:0] MIN_RANGE_RST  = 18'd20;
  localparam logic [17:0] MAX_RANGE_RST  = 18'd5600;
  localparam logic [7:0]  GAP_FACTOR_RST = 8'd26;
  localparam logic [15:0] GAP_OFFSET_RST = 16'd20;
  localparam logic [9:0]  MIN_STEPS_RST  = 10'd4;

  typedef struct packed {
    logic [17:0] min_range;
    logic [17:0] max_range;
    logic [7:0]  gap_factor;
    logic [15:0] gap_offset;
    logic [9:0]  min_steps;
  } cfg_t;

  // What the front end decided about one sample.
  typedef enum logic [1:0] {
    KIND_SEED,
    KIND_NEAR,
    KIND_JUMP,
    KIND_CLOSE
  } kind_t;

  typedef struct packed {
    logic [5:0]        segment_id;
    logic [9:0]        first_step;
    logic [8:0]        nearest_step;
    logic [DIST_W-1:0] nearest_distance;
    logic [9:0]        last_step;
    logic              scan_done;
    logic              overflow;
  } res_t;

endpackage

// File: hw/rtl/scan_obstacle_segmenter.sv
// Splits a laser scan into obstacle segments, one range sample per transaction.
// Input side: drive in_distance and raise in_push; the sample is taken at any
// edge where full is low. Output side: while out_empty is low the oldest segment
// record sits on the out_ ports; raising out_pop takes it.
// The configuration channel (cfg_valid, cfg_index, cfg_data) is always ready and
// should be written only while no samples are in flight.
// Throughput is one sample per cycle while full is low. A sample is classified
// against the previous sample in the front end in the cycle it is accepted,
// waits in a four-entry queue, and is applied to the open segment by the back
// end once it leaves that queue; a record that results passes through the
// result queue to the output. If the receiver stalls, the two-entry result
// queue fills, the back end holds, the middle queue fills and full rises.
// Reset (synchronous, rst_n low) empties both queues, restores the default
// configuration and starts a new scan at step 0.
module scan_obstacle_segmenter #(
  parameter int SAMPLES      = sos_pkg::SAMPLES_DEF,
  parameter int MAX_SEGMENTS = sos_pkg::MAX_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        full,
  input  logic [17:0] in_distance,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [5:0]  out_segment_id,
  output logic [9:0]  out_first_step,
  output logic [8:0]  out_nearest_step,
  output logic [17:0] out_nearest_distance,
  output logic [9:0]  out_last_step,
  output logic        out_scan_done,
  output logic        out_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import sos_pkg::*;

  localparam int SW    = $clog2(SAMPLES);
  localparam int MID_W = $bits(kind_t) + SW + DIST_W;
  localparam int RES_W = $bits(res_t);

  cfg_t              cfg_r, cfg_nxt;

  logic              mid_wr, mid_full, mid_empty, mid_rd;
  kind_t             f_kind;
  logic [SW-1:0]     f_step;
  logic [DIST_W-1:0] f_dist;
  logic [MID_W-1:0]  mid_wdata, mid_rdata;
  kind_t             b_kind;
  logic [SW-1:0]     b_step;
  logic [DIST_W-1:0] b_dist;

  logic              res_wr, res_full;
  res_t              res_in, res_out;
  logic [RES_W-1:0]  res_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_RANGE:  cfg_nxt.min_range  = cfg_data;
        CFG_MAX_RANGE:  cfg_nxt.max_range  = cfg_data;
        CFG_GAP_FACTOR: cfg_nxt.gap_factor = cfg_data[7:0];
        CFG_GAP_OFFSET: cfg_nxt.gap_offset = cfg_data[15:0];
        CFG_MIN_STEPS:  cfg_nxt.min_steps  = cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range  <= MIN_RANGE_RST;
      cfg_r.max_range  <= MAX_RANGE_RST;
      cfg_r.gap_factor <= GAP_FACTOR_RST;
      cfg_r.gap_offset <= GAP_OFFSET_RST;
      cfg_r.min_steps  <= MIN_STEPS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign full = mid_full;

  sos_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_distance (in_distance),
    .cfg         (cfg_r),
    .q_full      (mid_full),
    .q_wr        (mid_wr),
    .q_kind      (f_kind),
    .q_step      (f_step),
    .q_dist      (f_dist)
  );

  assign mid_wdata = {f_kind, f_step, f_dist};

  sos_fifo #(
    .W     (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_wr),
    .wr_data (mid_wdata),
    .full    (mid_full),
    .rd_en   (mid_rd),
    .rd_data (mid_rdata),
    .empty   (mid_empty)
  );

  assign b_kind = kind_t'(mid_rdata[MID_W-1 -: $bits(kind_t)]);
  assign b_step = mid_rdata[DIST_W +: SW];
  assign b_dist = mid_rdata[DIST_W-1:0];

  sos_back #(
    .SAMPLES      (SAMPLES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!mid_empty),
    .q_pop     (mid_rd),
    .q_kind    (b_kind),
    .q_step    (b_step),
    .q_dist    (b_dist),
    .min_steps (cfg_r.min_steps),
    .r_full    (res_full),
    .r_wr      (res_wr),
    .r_data    (res_in)
  );

  sos_fifo #(
    .W     (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_rdata),
    .empty   (out_empty)
  );

  assign res_out              = res_rdata;
  assign out_segment_id       = res_out.segment_id;
  assign out_first_step       = res_out.first_step;
  assign out_nearest_step     = res_out.nearest_step;
  assign out_nearest_distance = res_out.nearest_distance;
  assign out_last_step        = res_out.last_step;
  assign out_scan_done        = res_out.scan_done;
  assign out_overflow         = res_out.overflow;

endmodule

// File: hw/rtl/sos_fifo.sv
module sos_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/sos_front.sv
module sos_front #(
  parameter int SAMPLES = sos_pkg::SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [17:0]                in_distance,
  input  sos_pkg::cfg_t              cfg,
  input  logic                       q_full,
  output logic                       q_wr,
  output sos_pkg::kind_t             q_kind,
  output logic [$clog2(SAMPLES)-1:0] q_step,
  output logic [17:0]                q_dist
);
  import sos_pkg::*;

  localparam int SW = $clog2(SAMPLES);
  localparam logic [SW-1:0] LAST_STEP = SW'(SAMPLES - 1);

  logic [SW-1:0]     step_r, step_nxt;
  logic [DIST_W-1:0] prev_dist_r, prev_dist_nxt;
  logic              prev_inv_r, prev_inv_nxt;

  logic              accept;
  logic              in_range;
  logic              skip;
  logic [DIST_W-1:0] diff;
  logic [25:0]       prod;
  logic [26:0]       lhs;
  logic [26:0]       limit;
  kind_t             kind;

  assign accept   = in_push && !q_full;
  assign in_range = (in_distance >= cfg.min_range) && (in_distance <= cfg.max_range);
  assign diff     = (in_distance >= prev_dist_r) ? in_distance - prev_dist_r
                                                 : prev_dist_r - in_distance;
  assign prod     = 26'(cfg.gap_factor) * 26'(in_distance);
  assign lhs      = 27'({diff, 8'd0});
  assign limit    = 27'(prod) + 27'({cfg.gap_offset, 8'd0});

  always_comb begin
    kind          = KIND_JUMP;
    skip          = 1'b0;
    prev_dist_nxt = prev_dist_r;
    prev_inv_nxt  = prev_inv_r;
    step_nxt      = step_r;
    if (step_r == '0) begin
      kind          = KIND_SEED;
      prev_dist_nxt = in_distance;
      prev_inv_nxt  = 1'b0;
    end else if (step_r == LAST_STEP) begin
      kind = KIND_CLOSE;
    end else if (!in_range) begin
      // An out-of-range sample forces the next valid one to count as a jump.
      skip         = 1'b1;
      prev_inv_nxt = 1'b1;
    end else begin
      kind          = (!prev_inv_r && (lhs <= limit)) ? KIND_NEAR : KIND_JUMP;
      prev_dist_nxt = in_distance;
      prev_inv_nxt  = 1'b0;
    end
    if (accept) begin
      step_nxt = (step_r == LAST_STEP) ? '0 : step_r + 1'b1;
    end else begin
      prev_dist_nxt = prev_dist_r;
      prev_inv_nxt  = prev_inv_r;
    end
  end

  assign q_wr   = accept && !skip;
  assign q_kind = kind;
  assign q_step = step_r;
  assign q_dist = in_distance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      prev_dist_r <= '0;
      prev_inv_r  <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      prev_dist_r <= prev_dist_nxt;
      prev_inv_r  <= prev_inv_nxt;
    end
  end

endmodule

// File: hw/rtl/sos_back.sv
module sos_back #(
  parameter int SAMPLES      = sos_pkg::SAMPLES_DEF,
  parameter int MAX_SEGMENTS = sos_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  sos_pkg::kind_t             q_kind,
  input  logic [$clog2(SAMPLES)-1:0] q_step,
  input  logic [17:0]                q_dist,
  input  logic [9:0]                 min_steps,
  input  logic                       r_full,
  output logic                       r_wr,
  output sos_pkg::res_t              r_data
);
  import sos_pkg::*;

  localparam int SW  = $clog2(SAMPLES);
  localparam int IDW = $clog2(MAX_SEGMENTS);
  localparam logic [IDW-1:0] LAST_ID = IDW'(MAX_SEGMENTS - 1);

  logic [IDW-1:0]    seg_id_r, seg_id_nxt;
  logic [SW-1:0]     first_r, first_nxt;
  logic [SW-1:0]     nearest_r, nearest_nxt;
  logic [DIST_W-1:0] near_dist_r, near_dist_nxt;
  logic [SW-1:0]     last_r, last_nxt;
  logic              ovf_r, ovf_nxt;

  logic [SW-1:0]     span;
  logic              long_enough;
  logic              done;

  assign q_pop       = q_valid && !r_full;
  assign span        = q_step - first_r;
  assign long_enough = (10'(span) >= min_steps);

  always_comb begin
    seg_id_nxt    = seg_id_r;
    first_nxt     = first_r;
    nearest_nxt   = nearest_r;
    near_dist_nxt = near_dist_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;
    r_wr          = 1'b0;
    done          = 1'b0;
    if (q_pop) begin
      case (q_kind)
        KIND_SEED: begin
          seg_id_nxt    = '0;
          ovf_nxt       = 1'b0;
          first_nxt     = '0;
          nearest_nxt   = '0;
          near_dist_nxt = q_dist;
          last_nxt      = SW'(1);
        end
        KIND_NEAR: begin
          if (q_dist < near_dist_r) begin
            nearest_nxt   = q_step;
            near_dist_nxt = q_dist;
          end
          last_nxt = q_step;
        end
        KIND_JUMP: begin
          if (long_enough) begin
            if (seg_id_r == LAST_ID) begin
              ovf_nxt = 1'b1;
            end else begin
              r_wr          = 1'b1;
              seg_id_nxt    = seg_id_r + 1'b1;
              first_nxt     = q_step;
              nearest_nxt   = q_step;
              near_dist_nxt = q_dist;
              last_nxt      = q_step + 1'b1;
            end
          end
        end
        KIND_CLOSE: begin
          r_wr = 1'b1;
          done = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // The record always describes the segment as it stood before this item.
  always_comb begin
    r_data.segment_id       = 6'(seg_id_r);
    r_data.first_step       = 10'(first_r);
    r_data.nearest_step     = 9'(nearest_r);
    r_data.nearest_distance = near_dist_r;
    r_data.last_step        = 10'(last_r);
    r_data.scan_done        = done;
    r_data.overflow         = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_id_r    <= '0;
      first_r     <= '0;
      nearest_r   <= '0;
      near_dist_r <= '0;
      last_r      <= SW'(1);
      ovf_r       <= 1'b0;
    end else begin
      seg_id_r    <= seg_id_nxt;
      first_r     <= first_nxt;
      nearest_r   <= nearest_nxt;
      near_dist_r <= near_dist_nxt;
      last_r      <= last_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

endmodule

// File: tb/tb_scan_obstacle_segmenter.sv
`timescale 1ns / 100ps

module tb_scan_obstacle_segmenter;
  import sos_pkg::*;

  localparam int SAMPLES       = SAMPLES_DEF;
  localparam int MAX_SEGS      = MAX_SEGMENTS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        full;
  logic [17:0] in_distance;
  logic        out_empty;
  logic        out_pop;
  logic [5:0]  out_segment_id;
  logic [9:0]  out_first_step;
  logic [8:0]  out_nearest_step;
  logic [17:0] out_nearest_distance;
  logic [9:0]  out_last_step;
  logic        out_scan_done;
  logic        out_overflow;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [17:0] cfg_data;

  // Segmenter state as the predictor tracks it.
  cfg_t        seg_cfg;
  logic [9:0]  step_idx;
  logic [17:0] prev_dist;
  logic        prev_bad;
  logic [5:0]  seg_id;
  logic [9:0]  seg_first;
  logic [8:0]  seg_near;
  logic [17:0] seg_near_dist;
  logic [9:0]  seg_last;
  logic        ovf_seen;

  res_t pending_segments[$];
  res_t due_record;
  int   error_count;
  int   stall_cycles;
  int   send_idle_pct;
  int   pop_idle_pct;

  scan_obstacle_segmenter #(
    .SAMPLES      (SAMPLES),
    .MAX_SEGMENTS (MAX_SEGS)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .full                 (full),
    .in_distance          (in_distance),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_segment_id       (out_segment_id),
    .out_first_step       (out_first_step),
    .out_nearest_step     (out_nearest_step),
    .out_nearest_distance (out_nearest_distance),
    .out_last_step        (out_last_step),
    .out_scan_done        (out_scan_done),
    .out_overflow         (out_overflow),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic cfg_t make_setting(input logic [17:0] mn, input logic [17:0] mx,
                                        input logic [7:0] gf, input logic [15:0] go,
                                        input logic [9:0] ms);
    cfg_t c;
    c.min_range  = mn;
    c.max_range  = mx;
    c.gap_factor = gf;
    c.gap_offset = go;
    c.min_steps  = ms;
    return c;
  endfunction

  function automatic cfg_t random_setting();
    return make_setting(18'($urandom_range(0, 300)), 18'($urandom_range(1000, 262143)),
                        8'($urandom), 16'($urandom_range(0, 400)),
                        10'($urandom_range(0, 8)));
  endfunction

  function automatic res_t make_record(input logic done);
    res_t r;
    r.segment_id       = seg_id;
    r.first_step       = seg_first;
    r.nearest_step     = seg_near;
    r.nearest_distance = seg_near_dist;
    r.last_step        = seg_last;
    r.scan_done        = done;
    r.overflow         = ovf_seen;
    return r;
  endfunction

  function automatic void start_segment(input logic [9:0] s, input logic [17:0] d);
    seg_first     = s;
    seg_near      = s[8:0];
    seg_near_dist = d;
    seg_last      = s + 10'd1;
  endfunction

  // Applies one accepted sample to the tracked scan and queues any record it closes.
  task automatic advance_segments(input logic [17:0] d);
    longint unsigned gap;
    longint unsigned room;
    if (step_idx == 10'd0) begin
      seg_id   = '0;
      ovf_seen = 1'b0;
      start_segment(10'd0, d);
      prev_dist = d;
      prev_bad  = 1'b0;
    end else if (step_idx >= SAMPLES - 1) begin
      // The last sample of a scan is never examined; it only closes the scan.
      pending_segments.push_back(make_record(1'b1));
      step_idx = 10'd0;
      return;
    end else if (d < seg_cfg.min_range || d > seg_cfg.max_range) begin
      prev_bad = 1'b1;
    end else begin
      gap  = (d >= prev_dist) ? 64'(d) - 64'(prev_dist) : 64'(prev_dist) - 64'(d);
      room = 64'(seg_cfg.gap_factor) * 64'(d) + (64'(seg_cfg.gap_offset) << 8);
      if (!prev_bad && (gap << 8) <= room) begin
        if (d < seg_near_dist) begin
          seg_near      = step_idx[8:0];
          seg_near_dist = d;
        end
        seg_last = step_idx;
      end else if ((step_idx - seg_first) >= seg_cfg.min_steps) begin
        if (int'(seg_id) + 1 >= MAX_SEGS) begin
          ovf_seen = 1'b1;
        end else begin
          pending_segments.push_back(make_record(1'b0));
          seg_id = seg_id + 6'd1;
          start_segment(step_idx, d);
        end
      end
      prev_dist = d;
      prev_bad  = 1'b0;
    end
    step_idx = step_idx + 10'd1;
  endtask

  // Draws the next sample: close to the previous one, a jump, out of range, or anything.
  function automatic logic [17:0] pick_distance(input int near_pct, input int jump_pct,
                                                input int bad_pct);
    int unsigned roll;
    int unsigned tol;
    int unsigned delta;
    longint      lo;
    longint      hi;
    longint      cand;
    roll = $urandom_range(0, 99);
    lo   = longint'(seg_cfg.min_range);
    hi   = longint'(seg_cfg.max_range);
    if (lo > hi) return 18'($urandom);
    if (roll < near_pct) begin
      tol = ((int'(seg_cfg.gap_factor) * int'(prev_dist)) >> 8) + int'(seg_cfg.gap_offset);
      case ($urandom_range(0, 3))
        0: delta = tol;
        1: delta = tol + 1;
        default: delta = $urandom_range(0, tol);
      endcase
      cand = $urandom_range(0, 1) ? longint'(prev_dist) + delta
                                  : longint'(prev_dist) - delta;
      if (cand < lo) cand = lo;
      if (cand > hi) cand = hi;
      return 18'(cand);
    end
    if (roll < near_pct + jump_pct) return 18'($urandom_range(int'(lo), int'(hi)));
    if (roll < near_pct + jump_pct + bad_pct) begin
      if (lo > 0 && (hi == 262143 || $urandom_range(0, 1) == 1))
        return 18'($urandom_range(0, int'(lo) - 1));
      if (hi < 262143) return 18'($urandom_range(int'(hi) + 1, 262143));
    end
    return 18'($urandom);
  endfunction

  task automatic push_sample(input logic [17:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push     = 1'b1;
    in_distance = d;
    do @(posedge clk); while (full);
    advance_segments(d);
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_RANGE:  seg_cfg.min_range  = val;
      CFG_MAX_RANGE:  seg_cfg.max_range  = val;
      CFG_GAP_FACTOR: seg_cfg.gap_factor = val[7:0];
      CFG_GAP_OFFSET: seg_cfg.gap_offset = val[15:0];
      CFG_MIN_STEPS:  seg_cfg.min_steps  = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Samples that close nothing may still be in flight once the last record is out.
  task automatic wait_idle();
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_registers(input cfg_t c);
    wait_idle();
    write_reg(CFG_MIN_RANGE, c.min_range);
    write_reg(CFG_MAX_RANGE, c.max_range);
    write_reg(CFG_GAP_FACTOR, 18'(c.gap_factor));
    write_reg(CFG_GAP_OFFSET, 18'(c.gap_offset));
    write_reg(CFG_MIN_STEPS, 18'(c.min_steps));
  endtask

  // Opening of a scan under reset settings: seed at full scale, a jump that comes too
  // soon, samples below and above the range, an equal distance that must not move the
  // nearest step, and samples right on and just past the jump threshold.
  task automatic test_seed_and_jumps();
    logic [17:0] samples [16];
    samples = '{18'd262143, 18'd100, 18'd19, 18'd5601, 18'd20, 18'd22, 18'd20, 18'd5600,
                18'd5590, 18'd5000, 18'd1430, 18'd1280, 18'd1430, 18'd1279, 18'd0,
                18'd262143};
    foreach (samples[i]) push_sample(samples[i]);
  endtask

  task automatic test_register_extremes();
    set_registers(make_setting(18'd0, 18'h3FFFF, 8'hFF, 16'hFFFF, 10'd512));
    push_sample(18'd0);
    push_sample(18'h3FFFF);
    push_sample(18'h20000);
    push_sample(18'h2AAAA);
    push_sample(18'h15555);
    push_sample(18'd1);
    // With the range inverted every examined sample is out of range.
    set_registers(make_setting(18'h3FFFF, 18'd0, 8'd0, 16'd0, 10'd0));
    push_sample(18'h3FFFF);
    push_sample(18'd0);
    push_sample(18'd5000);
    write_reg(CFG_SPARE_INDEX, 18'h3FFFF);
  endtask

  task automatic test_random_scan(input int count, input cfg_t setting);
    set_registers(setting);
    repeat (count) push_sample(pick_distance(55, 25, 10));
  endtask

  // Nearly every sample opens a segment, so the id limit is reached well before this
  // run of samples ends.
  task automatic test_id_overflow();
    int sent;
    set_registers(make_setting(18'd0, 18'h3FFFF, 8'd0, 16'd0, 10'd0));
    sent = 0;
    do begin
      push_sample(pick_distance(5, 80, 5));
      sent++;
    end while (sent < 80);
  endtask

  task automatic test_scan_close();
    cfg_t c;
    c = random_setting();
    c.min_steps = 10'd1;
    set_registers(c);
    do push_sample(pick_distance(55, 25, 10)); while (step_idx != 10'd0);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (out_pop && !out_empty) begin
      if (pending_segments.size() == 0) begin
        $error("segment record %0d popped with none expected", out_segment_id);
        error_count++;
      end else begin
        due_record = pending_segments.pop_front();
        check_field("segment_id", due_record.segment_id, out_segment_id);
        check_field("first_step", due_record.first_step, out_first_step);
        check_field("nearest_step", due_record.nearest_step, out_nearest_step);
        check_field("nearest_distance", due_record.nearest_distance, out_nearest_distance);
        check_field("last_step", due_record.last_step, out_last_step);
        check_field("scan_done", due_record.scan_done, out_scan_done);
        check_field("overflow", due_record.overflow, out_overflow);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_scan_obstacle_segmenter NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop = ($urandom_range(0, 99) >= pop_idle_pct);
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_distance   = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    error_count   = 0;
    stall_cycles  = 0;
    send_idle_pct = 6;
    pop_idle_pct  = 76;
    seg_cfg = make_setting(MIN_RANGE_RST, MAX_RANGE_RST, GAP_FACTOR_RST, GAP_OFFSET_RST,
                           MIN_STEPS_RST);
    step_idx      = '0;
    prev_dist     = '0;
    prev_bad      = 1'b0;
    seg_id        = '0;
    seg_first     = '0;
    seg_near      = '0;
    seg_near_dist = '0;
    seg_last      = 10'd1;
    ovf_seen      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_seed_and_jumps();
    test_register_extremes();
    test_random_scan(150, make_setting(MIN_RANGE_RST, MAX_RANGE_RST, GAP_FACTOR_RST,
                                       GAP_OFFSET_RST, MIN_STEPS_RST));

    send_idle_pct = 76;
    pop_idle_pct  = 6;
    test_random_scan(120, random_setting());
    test_random_scan(120, random_setting());
    test_id_overflow();

    send_idle_pct = 0;
    pop_idle_pct  = 0;
    test_scan_close();
    test_random_scan(240, random_setting());

    wait_idle();
    if (error_count == 0) begin
      $display("tb_scan_obstacle_segmenter OK");
    end else begin
      $display("tb_scan_obstacle_segmenter NOT OK");
    end
    $finish;
  end

endmodule
